>>> sv/lic_pkg.sv
// Shared types, codes and default sizes for the id cache pool.
// Used by lic_ctrl, lic_datapath and lru_id_cache_pool_unit; no dependencies.
package lic_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int POOL_ENTRIES_DEF = 16;
    localparam int MAX_USER_ID_DEF  = 4095;

    // Request codes.
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_ALLOC  = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_DROP   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic capture;
        logic read;
        logic check;
        logic update;
    } lic_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic out_free;
    } lic_status_t;

endpackage

>>> sv/lic_ctrl.sv
// Sequencing state machine of the id cache pool.
// Depends on lic_pkg for the command and status structs.
module lic_ctrl
    import lic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  lic_status_t status,
    output lic_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_READ   = 5'b00100,
        S_CHECK  = 5'b01000,
        S_UPDATE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state: the map is cleared once after reset, then one item walks
    // through read, check and update.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:   state_next = S_CHECK;
            S_CHECK:  state_next = S_UPDATE;
            S_UPDATE:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands to the datapath.
    assign in_stall    = (state_reg != S_IDLE);
    assign cmd.clear   = (state_reg == S_CLEAR);
    assign cmd.capture = (state_reg == S_IDLE) && in_valid;
    assign cmd.read    = (state_reg == S_READ);
    assign cmd.check   = (state_reg == S_CHECK);
    assign cmd.update  = (state_reg == S_UPDATE) && status.out_free;

endmodule

>>> sv/lic_datapath.sv
// Datapath of the id cache pool: id map memory, slot table, recency ranks
// and the result register. Depends on lic_pkg.
module lic_datapath
    import lic_pkg::*;
#(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
    parameter int MAX_USER_ID  = MAX_USER_ID_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  lic_cmd_t                          cmd,
    output lic_status_t                       status,
    input  logic [1:0]                        req_type,
    input  logic [15:0]                       user_id,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        out_status,
    output logic [$clog2(POOL_ENTRIES)-1:0]   out_slot,
    output logic                              out_evicted,
    output logic [15:0]                       out_evicted_id,
    output logic [$clog2(POOL_ENTRIES+1)-1:0] out_entries_used
);

    localparam int SW        = $clog2(POOL_ENTRIES);
    localparam int CW        = $clog2(POOL_ENTRIES + 1);
    localparam int MAP_DEPTH = MAX_USER_ID + 1;
    localparam int AW        = $clog2(MAP_DEPTH);
    localparam logic [SW-1:0] RANK_LAST = SW'(POOL_ENTRIES - 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(POOL_ENTRIES);
    localparam logic [AW-1:0] ADDR_LAST = AW'(MAP_DEPTH - 1);

    // Map entry: top bit marks a written entry, the rest is the slot.
    logic [SW:0]    map_mem [MAP_DEPTH];
    logic [SW:0]    map_q_reg;
    logic           map_we;
    logic [SW:0]    map_wdata;
    logic [AW-1:0]  clr_addr_reg;

    // Request held for the length of the item.
    logic [1:0]     req_reg;
    logic [15:0]    id_reg;
    logic           rej_reg;

    // Slot table.
    logic [POOL_ENTRIES-1:0] valid_reg, valid_next;
    logic [SW-1:0]  rank_reg  [POOL_ENTRIES];
    logic [SW-1:0]  rank_next [POOL_ENTRIES];
    logic [15:0]    owner_reg [POOL_ENTRIES];
    logic [15:0]    owner_next[POOL_ENTRIES];
    logic [CW-1:0]  count_reg, count_next;

    // Results of the check step.
    logic           hit_reg;
    logic [SW-1:0]  hslot_reg;
    logic           full_reg;
    logic [SW-1:0]  target_reg;
    logic [15:0]    victim_owner_reg;

    // Result register.
    logic           out_valid_reg;
    logic [1:0]     ost_reg, ost_next;
    logic [SW-1:0]  oslot_reg, oslot_next;
    logic           oev_reg, oev_next;
    logic [15:0]    oevid_reg, oevid_next;

    // Check-step combinational values.
    logic           hit_c;
    logic [SW-1:0]  free_c;
    logic [SW-1:0]  victim_c;
    logic [SW-1:0]  mslot;
    logic [SW-1:0]  r;

    assign mslot = map_q_reg[SW-1:0];

    // Map memory: one write and one registered read port. After reset the
    // clearing pass writes every entry to zero, one address a cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            map_mem[clr_addr_reg] <= '0;
        end
        else if (map_we)
        begin
            map_mem[id_reg[AW-1:0]] <= map_wdata;
        end
        if (cmd.read)
        begin
            map_q_reg <= map_mem[id_reg[AW-1:0]];
        end
    end

    // Hit test and slot searches; a map entry counts only if its slot
    // is valid and still owned by this id.
    always_comb
    begin
        hit_c    = map_q_reg[SW] && valid_reg[mslot] && (owner_reg[mslot] == id_reg);
        free_c   = '0;
        victim_c = '0;
        for (int i = POOL_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_c = SW'(i);
            end
        end
        for (int i = POOL_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && rank_reg[i] == RANK_LAST)
            begin
                victim_c = SW'(i);
            end
        end
    end

    // Update step: state and result for one request.
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < POOL_ENTRIES; i++)
        begin
            rank_next[i]  = rank_reg[i];
            owner_next[i] = owner_reg[i];
        end
        map_we     = 1'b0;
        map_wdata  = {1'b1, target_reg};
        ost_next   = ST_OK;
        oslot_next = '0;
        oev_next   = 1'b0;
        oevid_next = '0;
        r          = rank_reg[hslot_reg];

        if (cmd.update)
        begin
            if (req_reg == REQ_DROP)
            begin
                valid_next = '0;
                count_next = '0;
            end
            else if (rej_reg)
            begin
                ost_next = ST_REJECT;
            end
            else if (req_reg == REQ_ALLOC && !hit_reg)
            begin
                // New entry in the lowest free slot or in place of the LRU one.
                for (int i = 0; i < POOL_ENTRIES; i++)
                begin
                    if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                rank_next[target_reg]  = '0;
                valid_next[target_reg] = 1'b1;
                owner_next[target_reg] = id_reg;
                map_we     = 1'b1;
                oslot_next = target_reg;
                if (full_reg)
                begin
                    oev_next   = 1'b1;
                    oevid_next = victim_owner_reg;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else if (!hit_reg)
            begin
                ost_next = ST_MISS;
            end
            else if (req_reg == REQ_REMOVE)
            begin
                // Free the slot and close the gap in the ranks.
                oslot_next = hslot_reg;
                valid_next[hslot_reg] = 1'b0;
                count_next = count_reg - 1'b1;
                for (int i = 0; i < POOL_ENTRIES; i++)
                begin
                    if (valid_reg[i] && rank_reg[i] > r)
                    begin
                        rank_next[i] = rank_reg[i] - 1'b1;
                    end
                end
            end
            else
            begin
                // Lookup hit or refresh: move the entry to the front.
                oslot_next = hslot_reg;
                for (int i = 0; i < POOL_ENTRIES; i++)
                begin
                    if (valid_reg[i] && rank_reg[i] < r)
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                rank_next[hslot_reg] = '0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_type;
            id_reg  <= user_id;
            rej_reg <= (user_id == 16'd0) || (32'(user_id) > 32'(MAX_USER_ID));
        end
        if (cmd.check)
        begin
            hit_reg          <= hit_c;
            hslot_reg        <= mslot;
            full_reg         <= (count_reg == COUNT_FULL);
            target_reg       <= (count_reg == COUNT_FULL) ? victim_c : free_c;
            victim_owner_reg <= owner_reg[victim_c];
        end
        for (int i = 0; i < POOL_ENTRIES; i++)
        begin
            rank_reg[i]  <= rank_next[i];
            owner_reg[i] <= owner_next[i];
        end
        if (cmd.update)
        begin
            ost_reg   <= ost_next;
            oslot_reg <= oslot_next;
            oev_reg   <= oev_next;
            oevid_reg <= oevid_next;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            clr_addr_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.update)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free   = !out_valid_reg || !out_stall;
    assign status.clear_done = (clr_addr_reg == ADDR_LAST);
    assign out_valid         = out_valid_reg;
    assign out_status        = ost_reg;
    assign out_slot          = oslot_reg;
    assign out_evicted       = oev_reg;
    assign out_evicted_id    = oevid_reg;
    assign out_entries_used  = count_reg;

endmodule

>>> sv/lru_id_cache_pool_unit.sv
// Top level of the id cache pool: a pool of slots keyed by user id in LRU order.
// Depends on lic_pkg, lic_ctrl and lic_datapath.
//
// Input channel (in_valid, in_stall) carries req_type and user_id: lookup,
// allocate or refresh, remove, or drop all. Output channel (out_valid,
// out_stall) returns one item per request: status, slot, evicted,
// evicted_id and entries_used after the request.
// One request is handled at a time. After the accepting edge it passes through
// the map memory read, the hit check with slot search, and the update of the
// slot table, which loads the result register. A new request can be taken in
// the cycle after the result register is loaded, so the block does not take a
// new request before it is through with the last one.
// After reset the pool is empty and the id map is cleared by a pass that
// writes one entry a cycle over all MAX_USER_ID + 1 entries (4096 by default),
// while the input is stalled.
// While the receiver stalls, the result holds and the next request waits in
// its update step until the result register is taken.
module lru_id_cache_pool_unit
    import lic_pkg::*;
#(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
    parameter int MAX_USER_ID  = MAX_USER_ID_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        req_type,
    input  logic [15:0]                       user_id,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic [$clog2(POOL_ENTRIES)-1:0]   slot,
    output logic                              evicted,
    output logic [15:0]                       evicted_id,
    output logic [$clog2(POOL_ENTRIES+1)-1:0] entries_used
);

    lic_cmd_t    cmd;
    lic_status_t dp_status;

    // Sequencer.
    lic_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (dp_status),
        .cmd      (cmd)
    );

    // Storage and update logic.
    lic_datapath #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .MAX_USER_ID  (MAX_USER_ID)
    ) u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (dp_status),
        .req_type         (req_type),
        .user_id          (user_id),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_status       (status),
        .out_slot         (slot),
        .out_evicted      (evicted),
        .out_evicted_id   (evicted_id),
        .out_entries_used (entries_used)
    );

endmodule

>>> dv/lru_id_cache_pool_unit_tb.sv
// Self-checking testbench for the LRU id cache pool: directed table, then random items.
// Depends on lic_pkg and the lru_id_cache_pool_unit RTL; needs nothing else.
module lru_id_cache_pool_unit_tb;
    import lic_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT  = POOL_ENTRIES_DEF;
    localparam int MAXID  = MAX_USER_ID_DEF;
    localparam int NRAND  = 1450;
    localparam int WDOG   = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic        evicted;
        logic [15:0] evicted_id;
        logic [4:0]  entries_used;
    } pool_reply_t;

    typedef struct {
        logic [1:0]  req;
        logic [15:0] id;
        logic        has_exp;
        pool_reply_t exp;
    } req_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] req_type = REQ_LOOKUP;
    logic [15:0] user_id = 16'd0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] status;
    logic [3:0] slot;
    logic evicted;
    logic [15:0] evicted_id;
    logic [4:0] entries_used;

    // Predictor state: map holds slot+1 or 0.
    logic [4:0]  pred_map [0:MAXID];
    logic [15:0] pred_owner [NSLOT];
    logic        pred_valid [NSLOT];
    logic [3:0]  pred_rank [NSLOT];
    int          pred_count;

    pool_reply_t pending_replies [$];
    int errors = 0;
    int idle_cycles = 0;
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;
    req_row_t rows [$];

    lru_id_cache_pool_unit dut (.*);

    initial begin
        forever #5 clk = ~clk;
    end

    // Move a slot to the front of the recency order.
    function automatic void touch_slot(int s);
        logic [3:0] r;
        r = pred_rank[s];
        for (int i = 0; i < NSLOT; i++)
            if (pred_valid[i] && pred_rank[i] < r)
                pred_rank[i]++;
        pred_rank[s] = 4'd0;
    endfunction

    // Release a slot and close the gap in the order.
    function automatic void release_slot(int s);
        logic [3:0] r;
        r = pred_rank[s];
        pred_map[pred_owner[s]] = 5'd0;
        pred_valid[s] = 1'b0;
        for (int i = 0; i < NSLOT; i++)
            if (pred_valid[i] && pred_rank[i] > r)
                pred_rank[i]--;
        if (pred_count > 0)
            pred_count--;
    endfunction

    // Work out the reply to one request and advance the predictor state.
    function automatic pool_reply_t pool_predict(logic [1:0] req, logic [15:0] id);
        pool_reply_t rep;
        int m;
        int victim;
        int fs;
        rep = '0;
        if (req == REQ_DROP) begin
            for (int i = 0; i <= MAXID; i++)
                pred_map[i] = 5'd0;
            for (int i = 0; i < NSLOT; i++)
            begin
                pred_valid[i] = 1'b0;
                pred_rank[i] = 4'd0;
            end
            pred_count = 0;
        end else if (id == 16'd0 || id > MAXID) begin
            rep.status = ST_REJECT;
        end else begin
            m = pred_map[id];
            if (m != 0 && !pred_valid[m-1])
                m = 0;
            if (req != REQ_ALLOC) begin
                if (m == 0)
                    rep.status = ST_MISS;
                else
                begin
                    rep.slot = 4'(m - 1);
                    if (req == REQ_LOOKUP)
                        touch_slot(m - 1);
                    else
                        release_slot(m - 1);
                end
            end else if (m != 0) begin
                rep.slot = 4'(m - 1);
                touch_slot(m - 1);
            end else begin
                if (pred_count >= NSLOT) begin
                    victim = -1;
                    for (int i = 0; i < NSLOT; i++)
                        if (pred_valid[i] && (victim < 0 || pred_rank[i] > pred_rank[victim]))
                            victim = i;
                    if (victim >= 0)
                    begin
                        rep.evicted = 1'b1;
                        rep.evicted_id = pred_owner[victim];
                        release_slot(victim);
                    end
                end
                fs = -1;
                for (int i = NSLOT - 1; i >= 0; i--)
                    if (!pred_valid[i])
                        fs = i;
                if (fs >= 0) begin
                    for (int k = 0; k < NSLOT; k++)
                        if (pred_valid[k])
                            pred_rank[k]++;
                    rep.slot = 4'(fs);
                    pred_valid[fs] = 1'b1;
                    pred_owner[fs] = id;
                    pred_rank[fs] = 4'd0;
                    pred_map[id] = 5'(fs + 1);
                    pred_count++;
                end
            end
        end
        rep.entries_used = 5'(pred_count);
        return rep;
    endfunction

    function automatic pool_reply_t fixed_reply(logic [1:0] st, int used);
        pool_reply_t rep;
        rep = '0;
        rep.status = st;
        rep.entries_used = 5'(used);
        return rep;
    endfunction

    // Offer one item and hold it until the block takes it. The valid line
    // drops only when the sender idles, so each step sees one assignment.
    task automatic send_item(logic [1:0] req, logic [15:0] id, logic has_exp,
                             pool_reply_t exp);
        pool_reply_t p;
        if (in_idle_pct > 0 && $urandom_range(99, 0) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99, 0) < in_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        user_id <= id;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        p = pool_predict(req, id);
        if (has_exp && p != exp)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch in directed row: expected %p, predicted %p", exp, p);
        end
        pending_replies.push_back(p);
    endtask

    // Random id: mostly from a small set so that hits and evictions happen.
    function automatic logic [15:0] pick_id();
        int c;
        c = $urandom_range(99, 0);
        if (c < 80)
            return 16'($urandom_range(24, 1));
        else if (c < 88)
            return 16'($urandom_range(MAXID, 1));
        else if (c < 92)
            return 16'd0;
        else if (c < 96)
            return 16'($urandom_range(65535, MAXID + 1));
        else
            return 16'($urandom);
    endfunction

    function automatic logic [1:0] pick_req();
        int c;
        c = $urandom_range(99, 0);
        if (c < 35)
            return REQ_LOOKUP;
        else if (c < 75)
            return REQ_ALLOC;
        else if (c < 97)
            return REQ_REMOVE;
        else
            return REQ_DROP;
    endfunction

    // Receiver: stall at random, or hold off for a long stretch when asked.
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= (out_idle_pct > 0) && ($urandom_range(99, 0) < out_idle_pct);
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        pool_reply_t got;
        pool_reply_t want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{status, slot, evicted, evicted_id, entries_used};
            if (pending_replies.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %p", got);
            end else begin
                want = pending_replies.pop_front();
                if (got != want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted item.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Long receiver hold-off while the sender keeps offering items; it starts
    // well after the map clearing pass that follows reset.
    initial begin
        wait (stim_done == 1'b0 && rst_n);
        repeat (6000) @(posedge clk);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    initial begin
        pool_reply_t z;
        z = '0;
        for (int i = 0; i <= MAXID; i++)
            pred_map[i] = 5'd0;
        for (int i = 0; i < NSLOT; i++)
        begin
            pred_valid[i] = 1'b0;
            pred_rank[i] = 4'd0;
            pred_owner[i] = 16'd0;
        end
        pred_count = 0;

        // Directed table: rejects, misses, fill, eviction, refresh, remove, drop.
        rows.push_back('{REQ_LOOKUP, 16'd5, 1'b1, fixed_reply(ST_MISS, 0)});
        rows.push_back('{REQ_ALLOC, 16'd0, 1'b1, fixed_reply(ST_REJECT, 0)});
        rows.push_back('{REQ_LOOKUP, 16'hFFFF, 1'b1, fixed_reply(ST_REJECT, 0)});
        rows.push_back('{REQ_REMOVE, 16'(MAXID + 1), 1'b1, fixed_reply(ST_REJECT, 0)});
        rows.push_back('{REQ_REMOVE, 16'd7, 1'b1, fixed_reply(ST_MISS, 0)});
        for (int i = 0; i < 16; i++)
            rows.push_back('{REQ_ALLOC, (i == 0) ? 16'(MAXID) : 16'(i), 1'b0, z});
        rows.push_back('{REQ_ALLOC, 16'd100, 1'b0, z});
        rows.push_back('{REQ_LOOKUP, 16'd3, 1'b0, z});
        rows.push_back('{REQ_ALLOC, 16'd2, 1'b0, z});
        rows.push_back('{REQ_REMOVE, 16'd4, 1'b0, z});
        rows.push_back('{REQ_DROP, 16'hFFFF, 1'b1, fixed_reply(ST_OK, 0)});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        in_idle_pct = 20;
        out_idle_pct = 61;
        foreach (rows[i])
            send_item(rows[i].req, rows[i].id, rows[i].has_exp, rows[i].exp);

        // Random part in three idling phases.
        for (int n = 0; n < NRAND; n++) begin
            if (n == NRAND / 3)
            begin
                in_idle_pct = 61;
                out_idle_pct = 20;
            end
            if (n == 2 * NRAND / 3)
            begin
                in_idle_pct = 0;
                out_idle_pct = 0;
            end
            send_item(pick_req(), pick_id(), 1'b0, z);
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> sim.f
sv/lic_pkg.sv
sv/lic_ctrl.sv
sv/lic_datapath.sv
sv/lru_id_cache_pool_unit.sv
dv/lru_id_cache_pool_unit_tb.sv
